@@ design/lslf_pkg.sv @@
// ---------------------------------------------------------------------------
// lslf_pkg
// Shared types, constants and helpers of the least-squares line fit block.
// ---------------------------------------------------------------------------
package lslf_pkg;

   // Point store and field sizes
   localparam int MAX_POINTS   = 64;
   localparam int SAMPLE_WIDTH = 24;
   localparam int SUM_WIDTH    = 31;
   localparam int PROD_WIDTH   = 53;
   localparam int COUNT_WIDTH  = 7;
   localparam int SIGMA_WIDTH  = 24;
   localparam int OUT_WIDTH    = 48;
   localparam int SU_WIDTH     = 32;

   localparam logic [SIGMA_WIDTH-1:0] SIGMA_RESET = 24'd6554;

   // Shared arithmetic unit sizes
   localparam int WIDE_WIDTH   = 80;
   localparam int OPND_WIDTH   = 64;
   localparam int CNT_WIDTH    = 7;
   localparam int DIV_STEPS    = WIDE_WIDTH;
   localparam int SQRT_STEPS   = 32;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic                  start;
      alu_op_type            op;
      logic                  neg;
      logic [WIDE_WIDTH-1:0] a;
      logic [OPND_WIDTH-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic                  done;
      logic [WIDE_WIDTH-1:0] result;
   } alu_rsp_type;

   // Clamp a sign/magnitude quotient into the signed 48-bit range
   function automatic logic [OUT_WIDTH-1:0] sat48(input logic [WIDE_WIDTH-1:0] q,
                                                  input logic neg);
      logic [WIDE_WIDTH-1:0] lim;
      logic [OUT_WIDTH-1:0]  m;
      lim = neg ? (WIDE_WIDTH'(1) << (OUT_WIDTH - 1))
                : ((WIDE_WIDTH'(1) << (OUT_WIDTH - 1)) - WIDE_WIDTH'(1));
      m   = (q > lim) ? lim[OUT_WIDTH-1:0] : q[OUT_WIDTH-1:0];
      return neg ? (~m + OUT_WIDTH'(1)) : m;
   endfunction

endpackage

@@ design/lslf_alu.sv @@
// ---------------------------------------------------------------------------
// lslf_alu
// Shared iterative unit: shift-add multiply, restoring divide, bitwise root.
// ---------------------------------------------------------------------------
module lslf_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  lslf_pkg::alu_req_type req,
   output lslf_pkg::alu_rsp_type rsp
);
   import lslf_pkg::*;

   localparam logic [OPND_WIDTH-1:0] SQRT_BIT0 = OPND_WIDTH'(1) << (OPND_WIDTH - 2);

   logic                  busy_ff;
   logic                  done_ff;
   alu_op_type            op_ff;
   logic                  neg_ff;
   logic [WIDE_WIDTH-1:0] acc_ff;
   logic [WIDE_WIDTH-1:0] sh_ff;
   logic [OPND_WIDTH-1:0] aux_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;
   logic [WIDE_WIDTH-1:0] result_ff;

   logic [WIDE_WIDTH-1:0] mul_sum;
   logic [OPND_WIDTH:0]   div_rem;
   logic [OPND_WIDTH:0]   div_diff;
   logic                  div_ge;
   logic [OPND_WIDTH:0]   sq_trial;
   logic                  sq_ge;
   logic [OPND_WIDTH-1:0] sq_root_in;

   // One step of each operation
   always_comb begin
      mul_sum    = acc_ff + sh_ff;
      div_rem    = {acc_ff[OPND_WIDTH-1:0], sh_ff[WIDE_WIDTH-1]};
      div_diff   = div_rem - {1'b0, aux_ff};
      div_ge     = (div_rem >= {1'b0, aux_ff});
      sq_trial   = {1'b0, sh_ff[OPND_WIDTH-1:0]} + {1'b0, aux_ff};
      sq_ge      = ({1'b0, acc_ff[OPND_WIDTH-1:0]} >= sq_trial);
      sq_root_in = sq_ge ? ((sh_ff[OPND_WIDTH-1:0] >> 1) + aux_ff)
                         : (sh_ff[OPND_WIDTH-1:0] >> 1);
   end

   // Load, iterate, finish
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff && req.start) begin
            busy_ff <= 1'b1;
            op_ff   <= req.op;
            neg_ff  <= req.neg;
            unique case (req.op)
               ALU_MUL: begin
                  acc_ff <= '0;
                  sh_ff  <= req.a;
                  aux_ff <= req.b;
                  cnt_ff <= '0;
               end
               ALU_DIV: begin
                  acc_ff <= '0;
                  sh_ff  <= req.a;
                  aux_ff <= req.b;
                  cnt_ff <= CNT_WIDTH'(DIV_STEPS);
               end
               ALU_SQRT: begin
                  acc_ff <= {{(WIDE_WIDTH-OPND_WIDTH){1'b0}}, req.a[OPND_WIDTH-1:0]};
                  sh_ff  <= '0;
                  aux_ff <= SQRT_BIT0;
                  cnt_ff <= CNT_WIDTH'(SQRT_STEPS);
               end
               default: begin
                  busy_ff <= 1'b0;
               end
            endcase
         end else if (busy_ff) begin
            unique case (op_ff)
               ALU_MUL: begin
                  if (aux_ff == '0) begin
                     result_ff <= neg_ff ? (~acc_ff + WIDE_WIDTH'(1)) : acc_ff;
                     done_ff   <= 1'b1;
                     busy_ff   <= 1'b0;
                  end else begin
                     if (aux_ff[0]) begin
                        acc_ff <= mul_sum;
                     end
                     sh_ff  <= sh_ff << 1;
                     aux_ff <= aux_ff >> 1;
                  end
               end
               ALU_DIV: begin
                  acc_ff <= {{(WIDE_WIDTH-OPND_WIDTH){1'b0}},
                             div_ge ? div_diff[OPND_WIDTH-1:0] : div_rem[OPND_WIDTH-1:0]};
                  sh_ff  <= {sh_ff[WIDE_WIDTH-2:0], div_ge};
                  cnt_ff <= cnt_ff - CNT_WIDTH'(1);
                  if (cnt_ff == CNT_WIDTH'(1)) begin
                     result_ff <= {sh_ff[WIDE_WIDTH-2:0], div_ge};
                     done_ff   <= 1'b1;
                     busy_ff   <= 1'b0;
                  end
               end
               ALU_SQRT: begin
                  if (sq_ge) begin
                     acc_ff <= acc_ff - {{(WIDE_WIDTH-OPND_WIDTH){1'b0}},
                                         sq_trial[OPND_WIDTH-1:0]};
                  end
                  sh_ff  <= {{(WIDE_WIDTH-OPND_WIDTH){1'b0}}, sq_root_in};
                  aux_ff <= aux_ff >> 2;
                  cnt_ff <= cnt_ff - CNT_WIDTH'(1);
                  if (cnt_ff == CNT_WIDTH'(1)) begin
                     result_ff <= {{(WIDE_WIDTH-OPND_WIDTH){1'b0}}, sq_root_in};
                     done_ff   <= 1'b1;
                     busy_ff   <= 1'b0;
                  end
               end
               default: begin
                  busy_ff <= 1'b0;
               end
            endcase
         end
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

@@ design/least_squares_line_fit.sv @@
// ---------------------------------------------------------------------------
// least_squares_line_fit
// Accumulates (x, y) points and fits a straight line on the last point.
// ---------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   req_x_sample req_y_sample req_last  start && !busy
//  result    rsp_slope ... rsp_point_count       rsp_valid, one cycle, no stall
//  config    csr_wr_data (sigma)                 csr_wr_en
//
//  A point runs x*y then x*x through the bit-serial multiplier of the shared
//  unit, each shifting through the bit length of the multiplier; a dropped
//  point without last starts no unit operation. A fit adds up to seven
//  multiplies, four 80-step divides and two 32-step roots, all in the one
//  shared unit; degenerate sets skip the slope, intercept and slope error
//  steps.
//  Synchronous active-high reset clears the sums, count and drop flag and
//  restores sigma to its reset value.
//  Results cannot be held off; rsp_valid strobes for one cycle per fit.
// ---------------------------------------------------------------------------
module least_squares_line_fit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [lslf_pkg::SAMPLE_WIDTH-1:0] req_x_sample,
   input  logic signed [lslf_pkg::SAMPLE_WIDTH-1:0] req_y_sample,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   output logic signed [lslf_pkg::OUT_WIDTH-1:0]  rsp_slope,
   output logic signed [lslf_pkg::OUT_WIDTH-1:0]  rsp_intercept,
   output logic [lslf_pkg::SU_WIDTH-1:0]          rsp_slope_uncertainty,
   output logic [lslf_pkg::SIGMA_WIDTH-1:0]       rsp_intercept_uncertainty,
   output logic                                   rsp_degenerate,
   output logic                                   rsp_overflow,
   output logic [lslf_pkg::COUNT_WIDTH-1:0]       rsp_point_count,
   input  logic                                   csr_wr_en,
   input  logic [lslf_pkg::SIGMA_WIDTH-1:0]       csr_wr_data
);
   import lslf_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} state_type;
   typedef enum logic [3:0] {
      ST_XY, ST_XX, ST_NSXY, ST_SXSY, ST_NSXX, ST_SXSX, ST_S2,
      ST_SLOPE, ST_MSX, ST_ICPT, ST_S2N, ST_SUDIV, ST_SUSQRT, ST_IUDIV, ST_IUSQRT
   } step_type;

   state_type                 state_ff;
   step_type                  step_ff;
   logic [SIGMA_WIDTH-1:0]    sigma_ff;
   logic [SUM_WIDTH-1:0]      sum_x_ff, sum_y_ff;
   logic [PROD_WIDTH-1:0]     sum_xy_ff, sum_xx_ff;
   logic [COUNT_WIDTH-1:0]    count_ff;
   logic                      dropped_ff;
   logic [SAMPLE_WIDTH-1:0]   x_ff, y_ff;
   logic                      last_ff;
   logic [OPND_WIDTH-1:0]     part_ff, num_ff, den_ff;
   logic [2*SIGMA_WIDTH-1:0]  s2_ff;
   logic [WIDE_WIDTH-1:0]     tmp_ff;
   logic [OUT_WIDTH-1:0]      m_ff, b_ff;
   logic [SU_WIDTH-1:0]       su_ff;
   logic                      degen_ff;
   logic                      rsp_valid_ff;
   logic [OUT_WIDTH-1:0]      slope_ff, intercept_ff;
   logic [SU_WIDTH-1:0]       slope_unc_ff;
   logic [SIGMA_WIDTH-1:0]    icpt_unc_ff;
   logic                      degenerate_ff, overflow_ff;
   logic [COUNT_WIDTH-1:0]    point_count_ff;

   alu_req_type               alu_req;
   alu_rsp_type               alu_rsp;

   logic [SAMPLE_WIDTH-1:0]   x_mag, y_mag;
   logic [SUM_WIDTH-1:0]      sx_mag, sy_mag;
   logic [PROD_WIDTH-1:0]     sxy_mag;
   logic [OPND_WIDTH-1:0]     num_mag;
   logic [OUT_WIDTH-1:0]      m_mag;
   logic [WIDE_WIDTH-1:0]     diff_mag;
   logic [WIDE_WIDTH-1:0]     sy_scaled;
   logic [WIDE_WIDTH-1:0]     diff_new;
   logic                      den_degen;

   // Magnitudes for the sign/magnitude unit
   always_comb begin
      x_mag     = x_ff[SAMPLE_WIDTH-1] ? (~x_ff + SAMPLE_WIDTH'(1)) : x_ff;
      y_mag     = y_ff[SAMPLE_WIDTH-1] ? (~y_ff + SAMPLE_WIDTH'(1)) : y_ff;
      sx_mag    = sum_x_ff[SUM_WIDTH-1] ? (~sum_x_ff + SUM_WIDTH'(1)) : sum_x_ff;
      sy_mag    = sum_y_ff[SUM_WIDTH-1] ? (~sum_y_ff + SUM_WIDTH'(1)) : sum_y_ff;
      sxy_mag   = sum_xy_ff[PROD_WIDTH-1] ? (~sum_xy_ff + PROD_WIDTH'(1)) : sum_xy_ff;
      num_mag   = num_ff[OPND_WIDTH-1] ? (~num_ff + OPND_WIDTH'(1)) : num_ff;
      m_mag     = m_ff[OUT_WIDTH-1] ? (~m_ff + OUT_WIDTH'(1)) : m_ff;
      diff_mag  = tmp_ff[WIDE_WIDTH-1] ? (~tmp_ff + WIDE_WIDTH'(1)) : tmp_ff;
      sy_scaled = {{(WIDE_WIDTH-SUM_WIDTH-16){sum_y_ff[SUM_WIDTH-1]}}, sum_y_ff, 16'b0};
      diff_new  = sy_scaled - alu_rsp.result;
      den_degen = den_ff[OPND_WIDTH-1] || (den_ff == '0);
   end

   // Operand select for the current step
   always_comb begin
      alu_req.start = (state_ff == S_ISSUE);
      alu_req.op    = ALU_MUL;
      alu_req.neg   = 1'b0;
      alu_req.a     = '0;
      alu_req.b     = '0;
      unique case (step_ff)
         ST_XY: begin
            alu_req.a   = WIDE_WIDTH'(x_mag);
            alu_req.b   = OPND_WIDTH'(y_mag);
            alu_req.neg = x_ff[SAMPLE_WIDTH-1] ^ y_ff[SAMPLE_WIDTH-1];
         end
         ST_XX: begin
            alu_req.a = WIDE_WIDTH'(x_mag);
            alu_req.b = OPND_WIDTH'(x_mag);
         end
         ST_NSXY: begin
            alu_req.a   = WIDE_WIDTH'(sxy_mag);
            alu_req.b   = OPND_WIDTH'(count_ff);
            alu_req.neg = sum_xy_ff[PROD_WIDTH-1];
         end
         ST_SXSY: begin
            alu_req.a   = WIDE_WIDTH'(sx_mag);
            alu_req.b   = OPND_WIDTH'(sy_mag);
            alu_req.neg = sum_x_ff[SUM_WIDTH-1] ^ sum_y_ff[SUM_WIDTH-1];
         end
         ST_NSXX: begin
            alu_req.a = WIDE_WIDTH'(sum_xx_ff);
            alu_req.b = OPND_WIDTH'(count_ff);
         end
         ST_SXSX: begin
            alu_req.a = WIDE_WIDTH'(sx_mag);
            alu_req.b = OPND_WIDTH'(sx_mag);
         end
         ST_S2: begin
            alu_req.a = WIDE_WIDTH'(sigma_ff);
            alu_req.b = OPND_WIDTH'(sigma_ff);
         end
         ST_SLOPE: begin
            alu_req.op = ALU_DIV;
            alu_req.a  = {num_mag, 16'b0};
            alu_req.b  = den_ff;
         end
         ST_MSX: begin
            alu_req.a   = WIDE_WIDTH'(m_mag);
            alu_req.b   = OPND_WIDTH'(sx_mag);
            alu_req.neg = m_ff[OUT_WIDTH-1] ^ sum_x_ff[SUM_WIDTH-1];
         end
         ST_ICPT: begin
            alu_req.op = ALU_DIV;
            alu_req.a  = diff_mag;
            alu_req.b  = OPND_WIDTH'({count_ff, 8'b0});
         end
         ST_S2N: begin
            alu_req.a = WIDE_WIDTH'(s2_ff);
            alu_req.b = OPND_WIDTH'(count_ff);
         end
         ST_SUDIV: begin
            alu_req.op = ALU_DIV;
            alu_req.a  = tmp_ff << 16;
            alu_req.b  = den_ff;
         end
         ST_SUSQRT: begin
            alu_req.op = ALU_SQRT;
            alu_req.a  = tmp_ff;
         end
         ST_IUDIV: begin
            alu_req.op = ALU_DIV;
            alu_req.a  = WIDE_WIDTH'(s2_ff);
            alu_req.b  = (count_ff == '0) ? OPND_WIDTH'(1) : OPND_WIDTH'(count_ff);
         end
         ST_IUSQRT: begin
            alu_req.op = ALU_SQRT;
            alu_req.a  = tmp_ff;
         end
         default: begin
            alu_req.a = '0;
         end
      endcase
   end

   lslf_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // Sequencer, accumulators and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_XY;
         sigma_ff     <= SIGMA_RESET;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_xy_ff    <= '0;
         sum_xx_ff    <= '0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            sigma_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  last_ff <= req_last;
                  x_ff    <= req_x_sample;
                  y_ff    <= req_y_sample;
                  if (count_ff < COUNT_WIDTH'(MAX_POINTS)) begin
                     sum_x_ff <= sum_x_ff + SUM_WIDTH'(req_x_sample);
                     sum_y_ff <= sum_y_ff + SUM_WIDTH'(req_y_sample);
                     count_ff <= count_ff + COUNT_WIDTH'(1);
                     step_ff  <= ST_XY;
                     state_ff <= S_ISSUE;
                  end else begin
                     dropped_ff <= 1'b1;
                     if (req_last) begin
                        step_ff  <= ST_NSXY;
                        state_ff <= S_ISSUE;
                     end
                  end
               end
            end
            S_ISSUE: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (alu_rsp.done) begin
                  state_ff <= S_ISSUE;
                  unique case (step_ff)
                     ST_XY: begin
                        sum_xy_ff <= sum_xy_ff + alu_rsp.result[PROD_WIDTH-1:0];
                        step_ff   <= ST_XX;
                     end
                     ST_XX: begin
                        sum_xx_ff <= sum_xx_ff + alu_rsp.result[PROD_WIDTH-1:0];
                        if (last_ff) begin
                           step_ff <= ST_NSXY;
                        end else begin
                           state_ff <= S_IDLE;
                        end
                     end
                     ST_NSXY: begin
                        part_ff <= alu_rsp.result[OPND_WIDTH-1:0];
                        step_ff <= ST_SXSY;
                     end
                     ST_SXSY: begin
                        num_ff  <= part_ff - alu_rsp.result[OPND_WIDTH-1:0];
                        step_ff <= ST_NSXX;
                     end
                     ST_NSXX: begin
                        part_ff <= alu_rsp.result[OPND_WIDTH-1:0];
                        step_ff <= ST_SXSX;
                     end
                     ST_SXSX: begin
                        den_ff  <= part_ff - alu_rsp.result[OPND_WIDTH-1:0];
                        step_ff <= ST_S2;
                     end
                     ST_S2: begin
                        s2_ff    <= alu_rsp.result[2*SIGMA_WIDTH-1:0];
                        degen_ff <= den_degen;
                        if (den_degen) begin
                           m_ff    <= '0;
                           b_ff    <= '0;
                           su_ff   <= '1;
                           step_ff <= ST_IUDIV;
                        end else begin
                           step_ff <= ST_SLOPE;
                        end
                     end
                     ST_SLOPE: begin
                        m_ff    <= sat48(alu_rsp.result, num_ff[OPND_WIDTH-1]);
                        step_ff <= ST_MSX;
                     end
                     ST_MSX: begin
                        tmp_ff  <= diff_new;
                        step_ff <= ST_ICPT;
                     end
                     ST_ICPT: begin
                        b_ff    <= sat48(alu_rsp.result, tmp_ff[WIDE_WIDTH-1]);
                        step_ff <= ST_S2N;
                     end
                     ST_S2N: begin
                        tmp_ff  <= alu_rsp.result;
                        step_ff <= ST_SUDIV;
                     end
                     ST_SUDIV: begin
                        tmp_ff <= alu_rsp.result;
                        if (alu_rsp.result[WIDE_WIDTH-1:OPND_WIDTH] != '0) begin
                           su_ff   <= '1;
                           step_ff <= ST_IUDIV;
                        end else begin
                           step_ff <= ST_SUSQRT;
                        end
                     end
                     ST_SUSQRT: begin
                        su_ff   <= alu_rsp.result[SU_WIDTH-1:0];
                        step_ff <= ST_IUDIV;
                     end
                     ST_IUDIV: begin
                        tmp_ff  <= alu_rsp.result;
                        step_ff <= ST_IUSQRT;
                     end
                     ST_IUSQRT: begin
                        icpt_unc_ff <= alu_rsp.result[SIGMA_WIDTH-1:0];
                        state_ff    <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_DONE: begin
               // Present the item and clear the point set
               rsp_valid_ff   <= 1'b1;
               slope_ff       <= m_ff;
               intercept_ff   <= b_ff;
               slope_unc_ff   <= su_ff;
               degenerate_ff  <= degen_ff;
               overflow_ff    <= dropped_ff;
               point_count_ff <= count_ff;
               sum_x_ff       <= '0;
               sum_y_ff       <= '0;
               sum_xy_ff      <= '0;
               sum_xx_ff      <= '0;
               count_ff       <= '0;
               dropped_ff     <= 1'b0;
               state_ff       <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                      = (state_ff != S_IDLE);
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_slope                 = slope_ff;
   assign rsp_intercept             = intercept_ff;
   assign rsp_slope_uncertainty     = slope_unc_ff;
   assign rsp_intercept_uncertainty = icpt_unc_ff;
   assign rsp_degenerate            = degenerate_ff;
   assign rsp_overflow              = overflow_ff;
   assign rsp_point_count           = point_count_ff;

`ifndef SYNTHESIS
   // A fit never follows in the next cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   // Degenerate fits carry zero line parameters and saturated slope error
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_slope == '0 && rsp_intercept == '0 && rsp_slope_uncertainty == '1)
      else $error("degenerate item with nonzero line");

   // Every fit uses at least one point and no more than the store holds
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_point_count != '0 &&
         rsp_point_count <= COUNT_WIDTH'(MAX_POINTS))
      else $error("point count out of range");
`endif

endmodule
